/* rtl/core/ppam_pkg.sv */
// shared types and constants of the period, phase and amplitude meter
`default_nettype none

package ppam_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int ADC_WIDTH   = 14;
    localparam int GAIN_WIDTH  = 16;
    localparam int PHASE_WIDTH = 16;
    localparam int STEP_WIDTH  = 4;

    // delay times the full-turn constant, also the quotient width
    localparam int PROD_WIDTH   = COUNT_WIDTH + GAIN_WIDTH;
    localparam int DIV_CNT_WIDTH = $clog2(PROD_WIDTH + 1);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [GAIN_WIDTH-1:0] RMS_GAIN_RESET = GAIN_WIDTH'(46341);
    localparam logic [GAIN_WIDTH-1:0] FULL_TURN_MUL  = GAIN_WIDTH'(36000);

    localparam logic [PROD_WIDTH-1:0] HALF_TURN       = PROD_WIDTH'(18000);
    localparam logic [PROD_WIDTH-1:0] FULL_TURN       = PROD_WIDTH'(36000);
    localparam logic [PROD_WIDTH-1:0] THREE_HALF_TURN = PROD_WIDTH'(54000);

    localparam logic signed [PHASE_WIDTH-1:0] PHASE_MAX = PHASE_WIDTH'(17999);
    localparam logic signed [PHASE_WIDTH-1:0] PHASE_MIN = -PHASE_WIDTH'(18000);

    // one finished measurement, handed from the tick sequencer to the math unit
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] period;
        logic [COUNT_WIDTH-1:0] delay;
        logic [ADC_WIDTH-1:0]   peak_a;
        logic [ADC_WIDTH-1:0]   peak_b;
        logic                   sat;
    } meas_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0]        period;
        logic signed [PHASE_WIDTH-1:0] phase;
        logic [ADC_WIDTH-1:0]          rms_a;
        logic [ADC_WIDTH-1:0]          rms_b;
        logic                          flag;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/ppam_seq.sv */
// tick sequencer: period, delay, peak capture, one tick per valid cycle
`default_nettype none

module ppam_seq (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           tick_valid,
    input  wire logic                           sig_a,
    input  wire logic                           sig_b,
    input  wire logic [ppam_pkg::ADC_WIDTH-1:0] adc_a,
    input  wire logic [ppam_pkg::ADC_WIDTH-1:0] adc_b,
    output logic                                meas_done,
    output ppam_pkg::meas_t                     meas
);

    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_PER_A_LO  = 4'd0;
    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_PER_A_HI  = 4'd1;
    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_PER_HIGH  = 4'd2;
    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_PER_LOW   = 4'd3;
    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_DLY_A_LO  = 4'd4;
    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_DLY_A_HI  = 4'd5;
    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_DLY_B_LO  = 4'd6;
    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_DLY_B_HI  = 4'd7;
    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_PK_A_ZERO = 4'd8;
    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_PK_A_POS  = 4'd9;
    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_PK_A_WAIT = 4'd10;
    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_PK_B_ZERO = 4'd11;
    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_PK_B_POS  = 4'd12;
    localparam logic [ppam_pkg::STEP_WIDTH-1:0] S_PK_B_WAIT = 4'd13;

    localparam logic [ppam_pkg::COUNT_WIDTH-1:0] CNT_ONE = ppam_pkg::COUNT_WIDTH'(1);

    logic [ppam_pkg::STEP_WIDTH-1:0]  step_reg, step_next;
    logic [ppam_pkg::COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [ppam_pkg::COUNT_WIDTH-1:0] period_reg, period_next;
    logic [ppam_pkg::COUNT_WIDTH-1:0] delay_reg, delay_next;
    logic [ppam_pkg::ADC_WIDTH-1:0]   peak_a_reg, peak_a_next;
    logic                             sat_reg, sat_next;

    logic                             cnt_at_max;
    logic [ppam_pkg::COUNT_WIDTH-1:0] cnt_inc;
    logic                             quarter_hit;
    logic                             done;

    assign cnt_at_max  = (cnt_reg == ppam_pkg::CNT_MAX);
    assign cnt_inc     = cnt_at_max ? cnt_reg : cnt_reg + CNT_ONE;
    assign quarter_hit = (cnt_inc >= (period_reg >> 2));

    always_comb begin
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        period_next = period_reg;
        delay_next  = delay_reg;
        peak_a_next = peak_a_reg;
        sat_next    = sat_reg;
        done        = 1'b0;
        if (tick_valid) begin
            case (step_reg)
                S_PER_A_LO, S_DLY_A_LO: begin
                    if (!sig_a) begin
                        step_next = step_reg + 4'd1;
                    end
                end
                S_PER_A_HI, S_DLY_A_HI: begin
                    if (sig_a) begin
                        cnt_next  = CNT_ONE;
                        step_next = step_reg + 4'd1;
                    end
                end
                S_PER_HIGH: begin
                    cnt_next = cnt_inc;
                    sat_next = sat_reg | cnt_at_max;
                    if (!sig_a) begin
                        step_next = S_PER_LOW;
                    end
                end
                S_PER_LOW: begin
                    if (sig_a) begin
                        period_next = cnt_reg;
                        step_next   = S_DLY_A_LO;
                    end else begin
                        cnt_next = cnt_inc;
                        sat_next = sat_reg | cnt_at_max;
                    end
                end
                S_DLY_B_LO: begin
                    cnt_next = cnt_inc;
                    sat_next = sat_reg | cnt_at_max;
                    if (!sig_b) begin
                        step_next = S_DLY_B_HI;
                    end
                end
                S_DLY_B_HI: begin
                    if (sig_b) begin
                        delay_next = cnt_reg;
                        step_next  = S_PK_A_ZERO;
                    end else begin
                        cnt_next = cnt_inc;
                        sat_next = sat_reg | cnt_at_max;
                    end
                end
                S_PK_A_ZERO: begin
                    if (adc_a == '0) begin
                        step_next = S_PK_A_POS;
                    end
                end
                S_PK_A_POS: begin
                    if (adc_a != '0) begin
                        cnt_next  = '0;
                        step_next = S_PK_A_WAIT;
                    end
                end
                S_PK_A_WAIT: begin
                    cnt_next = cnt_inc;
                    sat_next = sat_reg | cnt_at_max;
                    if (quarter_hit) begin
                        peak_a_next = adc_a;
                        step_next   = S_PK_B_ZERO;
                    end
                end
                S_PK_B_ZERO: begin
                    if (adc_b == '0) begin
                        step_next = S_PK_B_POS;
                    end
                end
                S_PK_B_POS: begin
                    if (adc_b != '0) begin
                        cnt_next  = '0;
                        step_next = S_PK_B_WAIT;
                    end
                end
                S_PK_B_WAIT: begin
                    cnt_next = cnt_inc;
                    sat_next = sat_reg | cnt_at_max;
                    if (quarter_hit) begin
                        done      = 1'b1;
                        cnt_next  = '0;
                        sat_next  = 1'b0;
                        step_next = S_PER_A_LO;
                    end
                end
                default: begin
                    step_next = S_PER_A_LO;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= S_PER_A_LO;
            cnt_reg    <= '0;
            period_reg <= '0;
            delay_reg  <= '0;
            peak_a_reg <= '0;
            sat_reg    <= 1'b0;
        end else begin
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
            period_reg <= period_next;
            delay_reg  <= delay_next;
            peak_a_reg <= peak_a_next;
            sat_reg    <= sat_next;
        end
    end

    // the last tick's own saturation still counts toward this measurement
    assign meas_done   = done;
    assign meas.period = period_reg;
    assign meas.delay  = delay_reg;
    assign meas.peak_a = peak_a_reg;
    assign meas.peak_b = adc_b;
    assign meas.sat    = sat_reg | cnt_at_max;

endmodule

`default_nettype wire

/* rtl/core/ppam_arith.sv */
// shared multiplier and radix-2 divider that turn a measurement into a result
`default_nettype none

module ppam_arith (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire ppam_pkg::meas_t                 meas,
    input  wire logic [ppam_pkg::GAIN_WIDTH-1:0] rms_gain,
    input  wire logic                            res_take,
    output logic                                 busy,
    output logic                                 res_valid,
    output ppam_pkg::result_t                    res
);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_DIV  = 2'd2;
    localparam logic [1:0] A_DONE = 2'd3;

    localparam logic [1:0] MUL_PHASE = 2'd0;
    localparam logic [1:0] MUL_RMS_A = 2'd1;
    localparam logic [1:0] MUL_RMS_B = 2'd2;

    localparam int CW = ppam_pkg::COUNT_WIDTH;
    localparam int PW = ppam_pkg::PROD_WIDTH;
    localparam int GW = ppam_pkg::GAIN_WIDTH;
    localparam int AW = ppam_pkg::ADC_WIDTH;

    logic [1:0]                          state_reg;
    logic [1:0]                          mul_idx_reg;
    logic [ppam_pkg::DIV_CNT_WIDTH-1:0]  div_cnt_reg;
    ppam_pkg::meas_t                     meas_reg;
    logic [PW-1:0]                       quo_reg;
    logic [CW-1:0]                       rem_reg;
    logic [AW-1:0]                       rms_a_reg;
    logic [AW-1:0]                       rms_b_reg;

    logic [CW-1:0] mul_op_a;
    logic [GW-1:0] mul_op_b;
    logic [PW-1:0] mul_prod;

    logic [CW:0]   trial;
    logic [CW:0]   diff;
    logic          trial_ge;

    always_comb begin
        case (mul_idx_reg)
            MUL_PHASE: begin
                mul_op_a = meas_reg.delay;
                mul_op_b = ppam_pkg::FULL_TURN_MUL;
            end
            MUL_RMS_A: begin
                mul_op_a = CW'(meas_reg.peak_a);
                mul_op_b = rms_gain;
            end
            MUL_RMS_B: begin
                mul_op_a = CW'(meas_reg.peak_b);
                mul_op_b = rms_gain;
            end
            default: begin
                mul_op_a = '0;
                mul_op_b = '0;
            end
        endcase
    end

    assign mul_prod = PW'(mul_op_a) * PW'(mul_op_b);

    // one quotient bit per cycle, dividend shifts out of quo_reg as bits shift in
    assign trial    = {rem_reg, quo_reg[PW-1]};
    assign trial_ge = (trial >= {1'b0, meas_reg.period});
    assign diff     = trial - {1'b0, meas_reg.period};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= A_IDLE;
            mul_idx_reg <= MUL_PHASE;
            div_cnt_reg <= '0;
        end else begin
            case (state_reg)
                A_IDLE: begin
                    if (start) begin
                        state_reg   <= A_MUL;
                        mul_idx_reg <= MUL_PHASE;
                    end
                end
                A_MUL: begin
                    if (mul_idx_reg == MUL_RMS_B) begin
                        state_reg   <= A_DIV;
                        div_cnt_reg <= ppam_pkg::DIV_CNT_WIDTH'(PW);
                    end
                    mul_idx_reg <= mul_idx_reg + 2'd1;
                end
                A_DIV: begin
                    if (div_cnt_reg == ppam_pkg::DIV_CNT_WIDTH'(1)) begin
                        state_reg <= A_DONE;
                    end
                    div_cnt_reg <= div_cnt_reg - ppam_pkg::DIV_CNT_WIDTH'(1);
                end
                A_DONE: begin
                    if (res_take) begin
                        state_reg <= A_IDLE;
                    end
                end
                default: begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == A_IDLE && start) begin
            meas_reg <= meas;
        end
        if (state_reg == A_MUL) begin
            case (mul_idx_reg)
                MUL_PHASE: begin
                    quo_reg <= mul_prod;
                    rem_reg <= '0;
                end
                MUL_RMS_A: rms_a_reg <= mul_prod[AW+GW-1:GW];
                MUL_RMS_B: rms_b_reg <= mul_prod[AW+GW-1:GW];
                default: begin
                end
            endcase
        end
        if (state_reg == A_DIV) begin
            quo_reg <= {quo_reg[PW-2:0], trial_ge};
            rem_reg <= trial_ge ? diff[CW-1:0] : trial[CW-1:0];
        end
    end

    // wrap once into the half-open range, clamp what is still too large
    always_comb begin
        res.period = meas_reg.period;
        res.rms_a  = rms_a_reg;
        res.rms_b  = rms_b_reg;
        res.flag   = meas_reg.sat;
        if (meas_reg.period == '0) begin
            res.phase = '0;
        end else if (quo_reg < ppam_pkg::HALF_TURN) begin
            res.phase = quo_reg[ppam_pkg::PHASE_WIDTH-1:0];
        end else if (quo_reg < ppam_pkg::THREE_HALF_TURN) begin
            res.phase = ppam_pkg::PHASE_WIDTH'(quo_reg - ppam_pkg::FULL_TURN);
        end else begin
            res.phase = ppam_pkg::PHASE_MAX;
            res.flag  = 1'b1;
        end
    end

    assign busy      = (state_reg != A_IDLE);
    assign res_valid = (state_reg == A_DONE);

`ifndef SYNTHESIS
    a_start_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == A_IDLE)
        else $error("measurement started while math unit busy");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_take |=> res_valid && $stable(res))
        else $error("pending result changed before hand-over");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> res.phase <= ppam_pkg::PHASE_MAX && res.phase >= ppam_pkg::PHASE_MIN)
        else $error("phase outside half-turn range");
`endif

endmodule

`default_nettype wire

/* rtl/core/period_phase_amplitude_meter_top.sv */
// top level of the period, phase and amplitude meter with stream ports
`default_nettype none

// Each input transaction is one timer tick carrying the levels of signals A and
// B and one ADC sample of each. While a measurement runs, one tick is taken
// every clock cycle with s_tvalid high. After the tick that captures the peak of
// B, the shared multiplier forms delay times 36000, then both RMS scalings, and
// the radix-2 divider works out the phase quotient; s_tready stays low until the
// result moves into the output register, which waits while the previous result
// sits unread there. The user writes rms_gain through cfg_we and cfg_wdata only
// while no measurement is pending, not enforced here; resets to 0.7071 in Q0.16.

module period_phase_amplitude_meter_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // sig_a [0], sig_b [1], adc_a [15:2], adc_b [29:16], zero [31:30]
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // period_ticks [23:0], phase_centideg [39:24], rms_a [53:40], rms_b [67:54],
    // zero [71:68]
    output logic [71:0]      m_tdata,
    // range_flag [0]
    output logic [0:0]       m_tuser
);

    localparam int AW = ppam_pkg::ADC_WIDTH;

    logic [ppam_pkg::GAIN_WIDTH-1:0] rms_gain_reg;
    logic                            s_accept;
    logic                            meas_done;
    ppam_pkg::meas_t                 meas;
    logic                            arith_busy;
    logic                            res_valid;
    ppam_pkg::result_t               res;
    logic                            out_load;
    logic                            m_tvalid_reg;
    ppam_pkg::result_t               out_reg;

    assign s_tready = !arith_busy;
    assign s_accept = s_tvalid && s_tready;
    assign out_load = res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rms_gain_reg <= ppam_pkg::RMS_GAIN_RESET;
        end else if (cfg_we) begin
            rms_gain_reg <= cfg_wdata;
        end
    end

    ppam_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_valid(s_accept),
        .sig_a     (s_tdata[0]),
        .sig_b     (s_tdata[1]),
        .adc_a     (s_tdata[AW+1:2]),
        .adc_b     (s_tdata[2*AW+1:AW+2]),
        .meas_done (meas_done),
        .meas      (meas)
    );

    ppam_arith u_arith (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (meas_done),
        .meas     (meas),
        .rms_gain (rms_gain_reg),
        .res_take (out_load),
        .busy     (arith_busy),
        .res_valid(res_valid),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_reg.rms_b, out_reg.rms_a, out_reg.phase, out_reg.period};
    assign m_tuser  = out_reg.flag;

`ifndef SYNTHESIS
    a_no_output_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !m_tvalid || m_tready)
        else $error("output register overwritten before transaction");

    a_no_tick_while_math: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_accept)
        else $error("tick taken while a result is pending");
`endif

endmodule

`default_nettype wire
